// ===== rtl/core/spitqf_pkg.sv =====
// Package for the SPI transmit-queue framer: beat types, command codes,
// framing constants and the job descriptor passed from control to emitter.
// No dependencies.
`default_nettype none

package spitqf_pkg;

  localparam int unsigned LenW = 11;
  localparam int unsigned SeqW = 5;

  localparam logic [7:0] OpWriteTxq = 8'h02;
  localparam logic [7:0] FillByte   = 8'hFF;
  // Top bits of the 0xC000 header word (first and last segment flags)
  localparam logic [4:0] SegFlags   = 5'b11000;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_TX_OK   = 2'd2,
    CMD_TX_FAIL = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [LenW-1:0] frame_length;
    logic [7:0]      payload_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_end;
  } out_t;

  typedef enum logic [1:0] {
    JOB_BEGIN = 2'd0,
    JOB_DATA  = 2'd1,
    JOB_LAST  = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic            valid;
    job_kind_e       kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic [SeqW-1:0] seq;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/spi_tx_queue_framer_top.sv =====
// Top level of the SPI transmit-queue framer: control stage plus byte
// emitter. Depends on spitqf_pkg, spitqf_ctrl and spitqf_emit.
`default_nettype none

// Frames packets into an SPI transmit-queue burst, one byte per output beat.
// A begin beat (non-zero length) yields 12 bytes: opcode 0x02, three 0xFF and
// the 8-byte header. Each payload beat inside a frame yields its byte; the
// last one is followed by 0xFF padding to a multiple of 4 and the 4-byte
// end-of-packet trailer, whose final byte carries burst_end. Transmit-ok
// bumps the 5-bit sequence number; fail/restart clears it and drops any open
// frame. Those, zero-length begins and stray payload beats yield nothing.
// Rate: one byte leaves per cycle, set by the output register, when not stalled.
// A beat holds the job register until its last byte loads: unstalled payload
// beats flow at one per cycle; a begin yields 12 bytes, a last payload 5 to 8.
// Two stages: a job register (frame state updated on accept) and the output
// register; a new beat is taken in the cycle the previous job drains.
module spi_tx_queue_framer_top
  import spitqf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  job_t job;       // registered job awaiting emission
  logic job_done;  // emitter takes the job's last byte this cycle

  spitqf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_done (job_done),
    .job      (job)
  );

  spitqf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_done  (job_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/spitqf_ctrl.sv =====
// Frame control for the SPI transmit-queue framer: decodes input beats,
// keeps sequence and frame state, registers one job for the emitter.
// Depends on spitqf_pkg.
`default_nettype none

module spitqf_ctrl
  import spitqf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  input  wire logic job_done,
  output job_t      job
);

  logic [SeqW-1:0] seq_num, seq_num_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic [LenW-1:0] held_length, held_length_next;
  logic            in_frame, in_frame_next;
  job_t            job_next;
  logic            accept;

  assign in_ready = !job.valid || job_done;
  assign accept   = in_valid && in_ready;

  always_comb begin
    seq_num_next     = seq_num;
    bytes_left_next  = bytes_left;
    held_length_next = held_length;
    in_frame_next    = in_frame;
    job_next         = job;
    if (job_done) begin
      job_next.valid = 1'b0;
    end
    if (accept) begin
      job_next.valid = 1'b0;
      job_next.data  = in_data.payload_byte;
      job_next.seq   = seq_num;
      job_next.len   = held_length;
      job_next.kind  = JOB_DATA;
      case (cmd_e'(in_data.cmd))
        CMD_BEGIN: begin
          if (in_data.frame_length != '0) begin
            held_length_next = in_data.frame_length;
            bytes_left_next  = in_data.frame_length;
            in_frame_next    = 1'b1;
            job_next.valid   = 1'b1;
            job_next.kind    = JOB_BEGIN;
            job_next.len     = in_data.frame_length;
          end
        end
        CMD_PAYLOAD: begin
          if (in_frame && bytes_left != '0) begin
            job_next.valid  = 1'b1;
            bytes_left_next = bytes_left - LenW'(1);
            if (bytes_left == LenW'(1)) begin
              job_next.kind = JOB_LAST;
              in_frame_next = 1'b0;
            end
          end
        end
        CMD_TX_OK: begin
          seq_num_next = seq_num + SeqW'(1);
        end
        CMD_TX_FAIL: begin
          seq_num_next    = '0;
          in_frame_next   = 1'b0;
          bytes_left_next = '0;
        end
        default: begin
          seq_num_next = seq_num;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_num     <= '0;
      bytes_left  <= '0;
      held_length <= '0;
      in_frame    <= 1'b0;
      job.valid   <= 1'b0;
    end else begin
      seq_num     <= seq_num_next;
      bytes_left  <= bytes_left_next;
      held_length <= held_length_next;
      in_frame    <= in_frame_next;
      job.valid   <= job_next.valid;
    end
    job.kind <= job_next.kind;
    job.data <= job_next.data;
    job.len  <= job_next.len;
    job.seq  <= job_next.seq;
  end

endmodule

`default_nettype wire

// ===== rtl/core/spitqf_emit.sv =====
// Byte emitter for the SPI transmit-queue framer: walks the held job one
// byte per cycle into the output register when not stalled. Depends on spitqf_pkg.
`default_nettype none

module spitqf_emit
  import spitqf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  output logic      job_done,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic [3:0]      idx, idx_next;
  logic [3:0]      last_idx;
  logic [1:0]      pad;
  logic [3:0]      tpos;
  logic [LenW-1:0] len_bar;
  logic [7:0]      byte_sel;
  logic            end_sel;
  logic            can_load, load;

  assign len_bar  = ~job.len;
  assign pad      = 2'(~job.len[1:0] + 2'd1);
  assign tpos     = idx - 4'd1 - {2'b00, pad};
  assign can_load = !out_valid || out_ready;
  assign load     = job.valid && can_load;
  assign job_done = load && (idx == last_idx);

  always_comb begin
    case (job.kind)
      JOB_BEGIN: last_idx = 4'd11;
      JOB_LAST:  last_idx = 4'd4 + {2'b00, pad};
      default:   last_idx = 4'd0;
    endcase
  end

  always_comb begin
    byte_sel = job.data;
    end_sel  = 1'b0;
    case (job.kind)
      JOB_BEGIN: begin
        case (idx)
          4'd0:    byte_sel = OpWriteTxq;
          4'd4:    byte_sel = {5'b00000, job.len[10:8]};
          4'd5:    byte_sel = job.len[7:0];
          4'd6:    byte_sel = {job.seq, len_bar[10:8]};
          4'd7:    byte_sel = len_bar[7:0];
          4'd8:    byte_sel = {SegFlags, job.len[10:8]};
          4'd9:    byte_sel = job.len[7:0];
          4'd10:   byte_sel = {5'b00000, len_bar[10:8]};
          4'd11:   byte_sel = len_bar[7:0];
          default: byte_sel = FillByte;
        endcase
      end
      JOB_LAST: begin
        if (idx == 4'd0) begin
          byte_sel = job.data;
        end else if (idx <= {2'b00, pad}) begin
          byte_sel = FillByte;
        end else begin
          case (tpos[1:0])
            2'd0:    byte_sel = {job.seq, job.len[10:8]};
            2'd1:    byte_sel = job.len[7:0];
            2'd2:    byte_sel = {~job.seq, len_bar[10:8]};
            default: begin
              byte_sel = len_bar[7:0];
              end_sel  = 1'b1;
            end
          endcase
        end
      end
      default: byte_sel = job.data;
    endcase
  end

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = job_done ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_data.out_byte  <= byte_sel;
      out_data.burst_end <= end_sel;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spitqf_checker.sv =====
// Port-level checks for the SPI transmit-queue framer, bound to the top.
// Depends on spitqf_pkg and spi_tx_queue_framer_top.
`default_nettype none

module spitqf_props
  import spitqf_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // Stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Nothing leaves straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A real begin beat reaches the output through the job and output registers
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == CMD_BEGIN && in_data.frame_length != '0
    |-> ##2 out_valid)
    else $error("begin beat produced no output");

  // Input is only held off while a beat is on the output or one is loading
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("input stalled with nothing moving out");

endmodule

bind spi_tx_queue_framer_top spitqf_props u_spitqf_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== test/spitqf_checker.sv =====
// Checker for the SPI transmit-queue framer: watches both channels, predicts
// the byte burst for every accepted input beat and compares output beats.
// Depends on spitqf_pkg.
`default_nettype none

module spitqf_checker
  import spitqf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_ready,
  input  wire in_t   in_data,
  input  wire logic  out_valid,
  input  wire logic  out_ready,
  input  wire out_t  out_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  // Predicted framing state
  logic [SeqW-1:0] frame_seq;
  logic [LenW-1:0] bytes_owed;
  logic [LenW-1:0] frame_len;
  logic            frame_open;

  out_t burst_bytes_q[$];

  task automatic push_byte(input logic [7:0] b, input logic tail);
    out_t ob;
    ob.out_byte  = b;
    ob.burst_end = tail;
    burst_bytes_q.push_back(ob);
  endtask

  // Big-endian 16-bit word
  task automatic push_word(input logic [15:0] w, input logic tail);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], tail);
  endtask

  task automatic frame_beat(input in_t beat);
    logic [LenW-1:0] len_inv;
    logic [1:0]      pad;
    case (beat.cmd)
      CMD_BEGIN: begin
        if (beat.frame_length != '0) begin
          len_inv    = ~beat.frame_length;
          frame_len  = beat.frame_length;
          bytes_owed = beat.frame_length;
          frame_open = 1'b1;
          push_byte(OpWriteTxq, 1'b0);
          repeat (3) push_byte(FillByte, 1'b0);
          push_word({5'd0, beat.frame_length}, 1'b0);
          push_word({frame_seq, len_inv}, 1'b0);
          push_word({SegFlags, beat.frame_length}, 1'b0);
          push_word({5'd0, len_inv}, 1'b0);
        end
      end
      CMD_PAYLOAD: begin
        if (frame_open && bytes_owed != '0) begin
          push_byte(beat.payload_byte, 1'b0);
          bytes_owed = bytes_owed - 1'b1;
          if (bytes_owed == '0) begin
            pad = 2'd0 - frame_len[1:0];
            repeat (pad) push_byte(FillByte, 1'b0);
            push_word({frame_seq, frame_len}, 1'b0);
            push_word({~frame_seq, ~frame_len}, 1'b1);
            frame_open = 1'b0;
          end
        end
      end
      CMD_TX_OK: begin
        frame_seq = frame_seq + 1'b1;
      end
      default: begin
        frame_seq  = '0;
        frame_open = 1'b0;
        bytes_owed = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      frame_seq  = '0;
      bytes_owed = '0;
      frame_len  = '0;
      frame_open = 1'b0;
      burst_bytes_q.delete();
    end else begin
      if (in_valid && in_ready) frame_beat(in_data);
      if (out_valid && out_ready) begin
        if (burst_bytes_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %h end %b",
                   $time, out_data.out_byte, out_data.burst_end);
          fail_count = fail_count + 1;
        end else begin
          want = burst_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h",
                     $time, want.out_byte, out_data.out_byte);
            fail_count = fail_count + 1;
          end
          if (out_data.burst_end !== want.burst_end) begin
            $display("%0t: burst_end expected %b actual %b",
                     $time, want.burst_end, out_data.burst_end);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = burst_bytes_q.size();
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench top for the SPI transmit-queue framer: clock, reset, stimulus
// and back-pressure, plus the final verdict. Depends on spitqf_pkg,
// spi_tx_queue_framer_top and spitqf_checker.
`default_nettype none

module tb_top
  import spitqf_pkg::*;
();

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandBeats  = 145;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // Sender and receiver idling controls; a calm side starts no new idle spell
  logic tx_calm    = 1'b0;
  logic rx_calm    = 1'b0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  spi_tx_queue_framer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  spitqf_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly short, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Receiver: random stalls while not calm; calm spells come and go so that
  // some stretches run with out_ready held high.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sends one input beat and returns in the step it is accepted, with valid
  // still high: the next call either keeps it high with a fresh payload or
  // drops it for a gap. Fields the command ignores carry random values.
  task automatic send_beat(input cmd_e c, input logic [LenW-1:0] len,
                           input logic [7:0] data);
    in_t beat;
    int  gap;
    gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    beat.cmd          = c;
    beat.frame_length = (c == CMD_BEGIN) ? len : LenW'($urandom);
    beat.payload_byte = (c == CMD_PAYLOAD) ? data : 8'($urandom);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_payload(input int unsigned count);
    repeat (count) send_beat(CMD_PAYLOAD, '0, 8'($urandom));
  endtask

  // Mostly short frames so all four padding cases come up often
  function automatic int unsigned frame_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 24);
    return $urandom_range(40, 70);
  endfunction

  initial begin
    int unsigned beats;
    int unsigned len;
    int unsigned part;
    int unsigned pick;
    cmd_e        noise_cmd;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: commands that yield nothing from a fresh state
    send_beat(CMD_TX_FAIL, '0, '0);
    send_beat(CMD_PAYLOAD, '0, 8'hA5);        // stray byte, dropped
    send_beat(CMD_BEGIN, '0, '0);             // zero length, ignored

    // Shortest frame: three fill bytes of padding
    send_beat(CMD_BEGIN, 11'd1, '0);
    send_beat(CMD_PAYLOAD, '0, 8'hFF);

    // Longest length, abandoned by a fresh begin mid-frame
    send_beat(CMD_TX_OK, '0, '0);
    send_beat(CMD_BEGIN, 11'd2047, '0);
    send_beat(CMD_PAYLOAD, '0, 8'h00);
    send_beat(CMD_BEGIN, 11'd2, '0);
    send_beat(CMD_PAYLOAD, '0, 8'h5A);
    send_beat(CMD_PAYLOAD, '0, 8'hC3);

    // Sequence bumped mid-frame: trailer takes the newer value
    send_beat(CMD_BEGIN, 11'd3, '0);
    send_beat(CMD_PAYLOAD, '0, 8'h01);
    send_beat(CMD_TX_OK, '0, '0);
    send_beat(CMD_PAYLOAD, '0, 8'h80);
    send_beat(CMD_PAYLOAD, '0, 8'h7F);

    // Whole words of payload: no padding
    send_beat(CMD_BEGIN, 11'd4, '0);
    send_payload(4);

    // Fail drops the open frame and clears the sequence; the byte after is stray
    send_beat(CMD_BEGIN, 11'd5, '0);
    send_beat(CMD_PAYLOAD, '0, 8'h3C);
    send_beat(CMD_TX_FAIL, '0, '0);
    send_beat(CMD_PAYLOAD, '0, 8'hE1);

    // Random part: mostly complete frames with random content, plus runs of
    // transmit-ok (long enough at times to wrap the sequence), abandoned
    // frames, restarts and plain noise.
    beats = 0;
    while (beats < RandBeats) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 55) begin
        len = frame_size();
        send_beat(CMD_BEGIN, LenW'(len), '0);
        send_payload(len);
        beats += 1 + len;
        if ($urandom_range(0, 1) == 0) begin
          send_beat(CMD_TX_OK, '0, '0);
          beats++;
        end
      end else if (pick < 65) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 35)
                                          : $urandom_range(1, 3);
        repeat (len) send_beat(CMD_TX_OK, '0, '0);
        beats += len;
      end else if (pick < 75) begin
        // Begin with any length, a few bytes, then maybe a restart; if left
        // open the next begin abandons it
        len  = $urandom_range(1, 2047);
        part = $urandom_range(0, (len > 5) ? 4 : len - 1);
        send_beat(CMD_BEGIN, LenW'(len), '0);
        send_payload(part);
        beats += 1 + part;
        if ($urandom_range(0, 1) == 0) begin
          send_beat(CMD_TX_FAIL, '0, '0);
          beats++;
        end
      end else if (pick < 85) begin
        send_beat(CMD_TX_FAIL, '0, '0);
        beats++;
      end else begin
        noise_cmd = cmd_e'($urandom_range(0, 3));
        send_beat(noise_cmd,
                  ($urandom_range(0, 3) == 0) ? '0 : LenW'($urandom),
                  8'($urandom));
        beats++;
      end
    end

    in_valid <= 1'b0;
    // Let the checker book the last accepted beat before pending is read
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog on the cycle counter
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
